// ===== hw/rtl/rilg_pkg.sv =====
// Shared types, constants and the exponent coefficient table for the Rasch item
// log-likelihood and gradient block. No dependencies.
package rilg_pkg;

    localparam int LUT_ADDR_BITS_DEF = 10;
    localparam int NODE_Q_DEPTH      = 2;

    localparam logic signed [15:0] B_LIMIT    = 16'sd20480;
    localparam logic signed [15:0] B_SUBST    = 16'sd3486;
    localparam logic [30:0]        ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0]        PROB_FLOOR = 31'd11;
    localparam logic [27:0]        LN2_Q28    = 28'd186065280;
    localparam logic [14:0]        LIMIT_RST  = 15'h7FFF;

    typedef enum logic {
        CFG_DIFFICULTY = 1'b0,
        CFG_EXP_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0]        ad;
        logic               neg;
        logic [23:0]        r;
        logic [23:0]        f;
        logic               last;
        logic signed [15:0] b;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP,
        S_DIV,
        S_PROB,
        S_NORM,
        S_SQR,
        S_SCALE,
        S_MUL,
        S_SUM,
        S_ACC,
        S_EMIT
    } t_state;

    // exp(-2^(j-12)) in Q1.30.
    function automatic logic [29:0] exp_coef(input logic [3:0] j);
        logic [29:0] c;
        unique case (j)
            4'd0:    c = 30'd1073479712;
            4'd1:    c = 30'd1073217664;
            4'd2:    c = 30'd1072693760;
            4'd3:    c = 30'd1071646719;
            4'd4:    c = 30'd1069553904;
            4'd5:    c = 30'd1065385899;
            4'd6:    c = 30'd1057118298;
            4'd7:    c = 30'd1040706261;
            4'd8:    c = 30'd1008687094;
            4'd9:    c = 30'd947573834;
            4'd10:   c = 30'd836230973;
            4'd11:   c = 30'd651257337;
            4'd12:   c = 30'd395007542;
            4'd13:   c = 30'd145315154;
            4'd14:   c = 30'd19666267;
            default: c = 30'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/rilg_fifo.sv =====
// Small register queue between the front and back parts.
// Depends on rilg_pkg for the default width and depth.
module rilg_fifo import rilg_pkg::*; #(
    parameter int WIDTH = NODE_W,
    parameter int DEPTH = NODE_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/rilg_front.sv =====
// Front part: configuration registers, input acceptance and node classification.
// Depends on rilg_pkg for the node type, register indexes and constants.
module rilg_front import rilg_pkg::*; #(
    parameter int LUT_ADDR_BITS = LUT_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_node_position,
    input  logic [23:0]        i_correct_count,
    input  logic [23:0]        i_total_count,
    input  logic               i_last_node,
    input  logic               i_q_full,
    output logic               o_push,
    output t_node              o_node
);
    localparam logic [14:0] CUT = 15'((1 << (15 - LUT_ADDR_BITS)) - 1);

    logic signed [15:0] r_difficulty;
    logic [14:0]        r_limit;
    logic signed [15:0] b;
    logic signed [16:0] d;
    logic signed [16:0] lim;
    logic signed [16:0] dc;
    logic [16:0]        mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_difficulty <= '0;
            r_limit      <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIFFICULTY: r_difficulty <= i_cfg_data;
                CFG_EXP_LIMIT:  r_limit      <= i_cfg_data[14:0];
                default:        r_limit      <= r_limit;
            endcase
        end
    end

    always_comb begin
        b   = (r_difficulty > B_LIMIT || r_difficulty < -B_LIMIT) ? B_SUBST : r_difficulty;
        d   = 17'(i_node_position) - 17'(b);
        lim = signed'({2'b00, r_limit});
        if (d > lim) begin
            dc = lim;
        end else if (d < -lim) begin
            dc = -lim;
        end else begin
            dc = d;
        end
        mag = dc[16] ? 17'(-dc) : 17'(dc);
        o_node.ad   = mag[14:0] & ~CUT;
        o_node.neg  = dc[16];
        o_node.r    = i_correct_count;
        o_node.f    = i_total_count;
        o_node.last = i_last_node;
        o_node.b    = b;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

// ===== hw/rtl/rilg_back.sv =====
// Back part: per-node probability, logarithms, accumulation and result register.
// Depends on rilg_pkg for the node type, state type, constants and coefficient table.
module rilg_back import rilg_pkg::*; #(
    parameter int LUT_ADDR_BITS = LUT_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_node              i_node,
    input  logic               i_node_avail,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_neg_loglik,
    output logic signed [47:0] o_gradient_sum,
    output logic signed [15:0] o_difficulty_used
);
    localparam logic [3:0]  LOW_BIT  = 4'(15 - LUT_ADDR_BITS);
    localparam logic [4:0]  EXP_LAST = 5'(LUT_ADDR_BITS - 1);
    localparam logic [30:0] CUT_MASK = ~31'((1 << (30 - LUT_ADDR_BITS)) - 1);
    localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;

    t_state             r_state, n_state;
    t_node              r_node;
    logic [30:0]        r_e;
    logic [4:0]         r_cnt;
    logic [31:0]        r_rem;
    logic [30:0]        r_q;
    logic [30:0]        r_p;
    logic [30:0]        r_qf;
    logic [30:0]        r_m;
    logic [4:0]         r_k;
    logic [29:0]        r_frac;
    logic               r_sel;
    logic [34:0]        r_nlp;
    logic [34:0]        r_nlq;
    logic [58:0]        r_t1;
    logic signed [60:0] r_t2;
    logic [54:0]        r_gp;
    logic signed [61:0] r_term;
    logic signed [56:0] r_grad;
    logic signed [47:0] r_lacc;
    logic signed [47:0] r_gacc;
    logic               r_ov;

    logic [3:0]         jidx;
    logic [60:0]        e_prod;
    logic [31:0]        den;
    logic [32:0]        rem2;
    logic               ge;
    logic [30:0]        p;
    logic [30:0]        pf;
    logic [30:0]        qd;
    logic [61:0]        sq;
    logic [34:0]        nl2;
    logic [62:0]        nl_prod;
    logic signed [48:0] lsum;
    logic signed [48:0] gsum;
    logic               slot_free;
    logic               load_out;

    assign jidx    = LOW_BIT + r_cnt[3:0];
    assign e_prod  = 61'(r_e) * 61'(exp_coef(jidx));
    assign den     = 32'(ONE_Q30) + 32'(r_e);
    assign rem2    = {r_rem, 1'b0};
    assign ge      = (rem2 >= 33'(den));
    assign p       = r_node.neg ? (ONE_Q30 - r_q) : r_q;
    assign pf      = (p < PROB_FLOOR) ? PROB_FLOOR : p;
    assign qd      = ONE_Q30 - pf;
    assign sq      = 62'(r_m) * 62'(r_m);
    assign nl2     = {r_k, 30'd0} - 35'(r_frac);
    assign nl_prod = 63'(nl2) * 63'(LN2_Q28);
    assign lsum    = 49'(r_lacc) + 49'(r_term >>> 22);
    assign gsum    = 49'(r_gacc) + 49'(r_grad >>> 22);
    assign slot_free = !r_ov || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_node_avail) n_state = S_EXP;
            S_EXP:   if (r_cnt == EXP_LAST) n_state = S_DIV;
            S_DIV:   if (r_cnt == 5'd0) n_state = S_PROB;
            S_PROB:  n_state = S_NORM;
            S_NORM:  if (r_m[30]) n_state = S_SQR;
            S_SQR:   if (r_cnt == 5'd29) n_state = S_SCALE;
            S_SCALE: n_state = r_sel ? S_MUL : S_NORM;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_ACC;
            S_ACC:   n_state = r_node.last ? S_EMIT : S_IDLE;
            S_EMIT:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == S_IDLE) && i_node_avail;
        load_out = (r_state == S_EMIT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_node <= i_node;
                r_e    <= ONE_Q30;
                r_cnt  <= '0;
            end
            S_EXP: begin
                if (r_node.ad[jidx]) begin
                    r_e <= e_prod[60:30];
                end
                if (r_cnt == EXP_LAST) begin
                    r_rem <= 32'h2000_0000;
                    r_cnt <= 5'd30;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            S_DIV: begin
                r_rem <= ge ? 32'(rem2 - 33'(den)) : rem2[31:0];
                r_q   <= {r_q[29:0], ge};
                r_cnt <= r_cnt - 5'd1;
            end
            S_PROB: begin
                r_p   <= p;
                r_m   <= pf;
                r_qf  <= (qd < PROB_FLOOR) ? PROB_FLOOR : qd;
                r_k   <= '0;
                r_sel <= 1'b0;
            end
            S_NORM: begin
                if (!r_m[30]) begin
                    r_m <= {r_m[29:0], 1'b0};
                    r_k <= r_k + 5'd1;
                end else begin
                    r_m    <= r_m & CUT_MASK;
                    r_cnt  <= '0;
                    r_frac <= '0;
                end
            end
            S_SQR: begin
                r_m    <= sq[61] ? sq[61:31] : sq[60:30];
                r_frac <= {r_frac[28:0], sq[61]};
                r_cnt  <= r_cnt + 5'd1;
            end
            S_SCALE: begin
                if (!r_sel) begin
                    r_nlp <= nl_prod[62:28];
                    r_m   <= r_qf;
                    r_k   <= '0;
                    r_sel <= 1'b1;
                end else begin
                    r_nlq <= nl_prod[62:28];
                end
            end
            S_MUL: begin
                r_t1 <= 59'(r_node.r) * 59'(r_nlp);
                r_t2 <= 61'(signed'(25'(r_node.f) - 25'(r_node.r)))
                        * 61'(signed'({1'b0, r_nlq}));
                r_gp <= 55'(r_node.f) * 55'(r_p);
            end
            S_SUM: begin
                r_term <= signed'(62'(r_t1)) + 62'(r_t2);
                r_grad <= signed'(57'({r_node.r, 30'd0})) - signed'(57'(r_gp));
            end
            default: begin
                r_e <= r_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lacc <= '0;
            r_gacc <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_state == S_ACC) begin
                r_lacc <= (lsum > ACC_MAX) ? 48'(ACC_MAX) :
                          (lsum < ACC_MIN) ? 48'(ACC_MIN) : 48'(lsum);
                r_gacc <= (gsum > ACC_MAX) ? 48'(ACC_MAX) :
                          (gsum < ACC_MIN) ? 48'(ACC_MIN) : 48'(gsum);
            end else if (load_out) begin
                r_lacc <= '0;
                r_gacc <= '0;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_neg_loglik      <= r_lacc;
            o_gradient_sum    <= r_gacc;
            o_difficulty_used <= r_node.b;
        end
    end

    assign o_valid = r_ov;

`ifndef SYNTHESIS
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROB) |-> (r_q <= ONE_Q30))
        else $error("Quotient exceeds one in Q1.30.");
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR) |-> r_m[30])
        else $error("Log mantissa left the range one to two.");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_lacc == '0 && r_gacc == '0 && r_ov))
        else $error("Sums not cleared after a result was loaded.");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_EXP))
        else $error("Node taken without starting the exponent stage.");
`endif

endmodule

// ===== hw/rtl/rasch_item_loglik_gradient_top.sv =====
// Top level of the Rasch item log-likelihood and gradient block.
// Depends on rilg_pkg, rilg_front, rilg_fifo and rilg_back.
//
// The back part takes each quadrature node in turn through the exponent, the divider, two
// logarithms (each normalising its argument by a shift k, up to 27 and at most 28 for both
// together, before its squaring steps) and the accumulation, with an emit state added on
// the last node of an item. A shared multiply-and-iterate engine runs the exponent product,
// a bit-per-cycle divider and two 30-step squaring logarithms in turn, so a node is
// finished before the next is taken. A two-entry queue lets the front accept nodes while
// the back is busy, and the result register lets the back continue while a result waits.
module rasch_item_loglik_gradient_top import rilg_pkg::*; #(
    parameter int LUT_ADDR_BITS = LUT_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_node_position,
    input  logic [23:0]        i_correct_count,
    input  logic [23:0]        i_total_count,
    input  logic               i_last_node,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_neg_loglik,
    output logic signed [47:0] o_gradient_sum,
    output logic signed [15:0] o_difficulty_used
);
    t_node              push_node;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic [NODE_W-1:0]  q_data;

    rilg_front #(.LUT_ADDR_BITS(LUT_ADDR_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_node_position (i_node_position),
        .i_correct_count (i_correct_count),
        .i_total_count   (i_total_count),
        .i_last_node     (i_last_node),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_node          (push_node)
    );

    rilg_fifo #(.WIDTH(NODE_W), .DEPTH(NODE_Q_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_node),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rilg_back #(.LUT_ADDR_BITS(LUT_ADDR_BITS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_node            (t_node'(q_data)),
        .i_node_avail      (!q_empty),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_neg_loglik      (o_neg_loglik),
        .o_gradient_sum    (o_gradient_sum),
        .o_difficulty_used (o_difficulty_used)
    );

endmodule
